>>> rtl/core/osvf_pkg.sv
// Package for the oversampled state-variable filter: widths, fixed-point constants,
// payload and control types, saturation helpers and the sequencer microcode table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package osvf_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int STATE_WIDTH = 32;
	localparam int FRAC = 22;
	localparam int CTRL_W = 16;

	localparam int COEF_W = 24;
	localparam int POLY_W = COEF_W + 2;
	localparam int OPA_W = STATE_WIDTH + 2;
	localparam int P_W = OPA_W + COEF_W + 1;
	localparam int R_W = P_W - FRAC;
	localparam int EXT_W = R_W + 2;
	localparam int ACC_W = R_W + 1;
	localparam int Y_W = R_W + 10;
	localparam int XE_W = SAMPLE_WIDTH + STATE_WIDTH;

	localparam int XSH = SAMPLE_WIDTH - 23;
	localparam int XSH_L = (XSH > 0) ? XSH : 0;
	localparam int XSH_R = (XSH < 0) ? -XSH : 0;

	localparam int ANGLE_PROD_W = 38;
	localparam int ANGLE_SHIFT = 16;
	localparam logic [ANGLE_PROD_W-1:0] ANGLE_K = ANGLE_PROD_W'(2178742);
	localparam logic [ANGLE_PROD_W-1:0] ANGLE_ROUND = ANGLE_PROD_W'(32768);
	localparam int DAMP_SHIFT = 6;
	localparam logic [CTRL_W:0] DAMP_ONE = {1'b1, {CTRL_W{1'b0}}};

	localparam logic [COEF_W-1:0] TAYLOR3 = COEF_W'(699051);
	localparam logic [COEF_W-1:0] TAYLOR5 = COEF_W'(34953);
	localparam logic [COEF_W-1:0] TAYLOR7 = COEF_W'(832);
	localparam logic [COEF_W-1:0] THIRD_Q22 = COEF_W'(1398101);
	localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(2097152);

	localparam logic signed [EXT_W-1:0] ST_MAX = EXT_W'({1'b0, {(STATE_WIDTH-1){1'b1}}});
	localparam logic signed [EXT_W-1:0] ST_MIN = ~ST_MAX;
	localparam logic signed [Y_W-1:0] SMP_MAX = Y_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	localparam logic signed [Y_W-1:0] SMP_MIN = ~SMP_MAX;

	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CUTOFF = 1'd1;
	localparam logic [CTRL_W-1:0] MIN_CUTOFF_RST = 16'd30;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int STEP_W = 5;
	localparam int SEQ_LAST = 28;

	typedef enum logic [MODE_W-1:0] {
		MODE_BYPASS = 3'd0,
		MODE_LOWPASS = 3'd1,
		MODE_HIGHPASS = 3'd2,
		MODE_BANDPASS = 3'd3,
		MODE_NOTCH = 3'd4
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] filter_mode;
		logic [CTRL_W-1:0] min_cutoff;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic signed [SAMPLE_WIDTH-1:0] raw;
		logic signed [STATE_WIDTH-1:0] x;
		logic [COEF_W-1:0] w;
		logic [COEF_W-1:0] q;
	} job_t;

	typedef enum logic [3:0] {
		OPA_ANGLE, OPA_W2, OPA_W3, OPA_W5, OPA_W7, OPA_BP, OPA_HP, OPA_AVG1, OPA_SH
	} opa_t;

	typedef enum logic [2:0] {
		OPB_W, OPB_W2, OPB_T3, OPB_T5, OPB_T7, OPB_F, OPB_Q, OPB_THIRD
	} opb_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_W2, DST_W3, DST_W5, DST_W7, DST_T3, DST_T5, DST_T7,
		DST_LP, DST_HP, DST_BP, DST_ACC_SET, DST_ACC_ADD, DST_OUT
	} dst_t;

	typedef struct packed {
		logic issue;
		opa_t opa;
		opb_t opb;
		dst_t dst;
	} micro_t;

	function automatic micro_t mk_op(input logic issue, input opa_t opa, input opb_t opb,
			input dst_t dst);
		micro_t m;
		m.issue = issue;
		m.opa = opa;
		m.opb = opb;
		m.dst = dst;
		return m;
	endfunction

	// Each step may start one multiply and retire the one started in the step before.
	function automatic micro_t seq_op(input logic [STEP_W-1:0] step);
		micro_t m;
		unique case (step)
			5'd0: m = mk_op(1'b1, OPA_ANGLE, OPB_W, DST_NONE);
			5'd1: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_W2);
			5'd2: m = mk_op(1'b1, OPA_W2, OPB_W, DST_NONE);
			5'd3: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_W3);
			5'd4: m = mk_op(1'b1, OPA_W3, OPB_W2, DST_NONE);
			5'd5: m = mk_op(1'b1, OPA_W3, OPB_T3, DST_W5);
			5'd6: m = mk_op(1'b1, OPA_W5, OPB_W2, DST_T3);
			5'd7: m = mk_op(1'b1, OPA_W5, OPB_T5, DST_W7);
			5'd8: m = mk_op(1'b1, OPA_W7, OPB_T7, DST_T5);
			5'd9: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_T7);
			5'd10, 5'd15, 5'd20: m = mk_op(1'b1, OPA_BP, OPB_F, DST_NONE);
			5'd11, 5'd16, 5'd21: m = mk_op(1'b1, OPA_BP, OPB_Q, DST_LP);
			5'd12, 5'd17, 5'd22: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_HP);
			5'd13, 5'd18, 5'd23: m = mk_op(1'b1, OPA_HP, OPB_F, DST_NONE);
			5'd14, 5'd19, 5'd24: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_BP);
			5'd25: m = mk_op(1'b1, OPA_AVG1, OPB_THIRD, DST_NONE);
			5'd26: m = mk_op(1'b1, OPA_SH, OPB_THIRD, DST_ACC_SET);
			5'd27: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_ACC_ADD);
			5'd28: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_OUT);
			default: m = mk_op(1'b0, OPA_ANGLE, OPB_W, DST_NONE);
		endcase
		return m;
	endfunction

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [EXT_W-1:0] v);
		logic signed [STATE_WIDTH-1:0] o;
		if (v > ST_MAX) begin
			o = STATE_WIDTH'(ST_MAX);
		end else if (v < ST_MIN) begin
			o = STATE_WIDTH'(ST_MIN);
		end else begin
			o = STATE_WIDTH'(v);
		end
		return o;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [Y_W-1:0] v);
		logic signed [SAMPLE_WIDTH-1:0] o;
		if (v > SMP_MAX) begin
			o = SAMPLE_WIDTH'(SMP_MAX);
		end else if (v < SMP_MIN) begin
			o = SAMPLE_WIDTH'(SMP_MIN);
		end else begin
			o = SAMPLE_WIDTH'(v);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/osvf_if.sv
// Valid/ready channel interfaces for the filter's sample input and output.
// Depends on osvf_pkg for the sample and control widths.
`default_nettype none

interface osvf_in_if;
	logic valid;
	logic ready;
	logic signed [osvf_pkg::SAMPLE_WIDTH-1:0] sample_in;
	logic [osvf_pkg::CTRL_W-1:0] cutoff;
	logic [osvf_pkg::CTRL_W-1:0] resonance;

	modport source (output valid, output sample_in, output cutoff, output resonance,
		input ready);
	modport sink (input valid, input sample_in, input cutoff, input resonance,
		output ready);
endinterface

interface osvf_out_if;
	logic valid;
	logic ready;
	logic signed [osvf_pkg::SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/osvf_front.sv
// Front end: accepts input beats, classifies them as bypass or filter jobs and
// prepares the sample, angle and damping. Depends on osvf_pkg and osvf_in_if.
`default_nettype none

module osvf_front (
	osvf_in_if.sink in_ch,
	input osvf_pkg::cfg_t cfg,
	input logic full,
	output logic push,
	output osvf_pkg::job_t job
);

	logic signed [osvf_pkg::XE_W-1:0] xe;
	logic [osvf_pkg::CTRL_W-1:0] c_eff;
	logic [osvf_pkg::ANGLE_PROD_W-1:0] wprod;
	logic [osvf_pkg::CTRL_W:0] damp;

	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full;

	always_comb begin
		xe = (osvf_pkg::XE_W'(in_ch.sample_in) <<< osvf_pkg::XSH_R) >>> osvf_pkg::XSH_L;
		c_eff = (in_ch.cutoff < cfg.min_cutoff) ? cfg.min_cutoff : in_ch.cutoff;
		wprod = osvf_pkg::ANGLE_PROD_W'(c_eff) * osvf_pkg::ANGLE_K + osvf_pkg::ANGLE_ROUND;
		damp = osvf_pkg::DAMP_ONE - {1'b0, in_ch.resonance};

		job.raw = in_ch.sample_in;
		job.x = xe[osvf_pkg::STATE_WIDTH-1:0];
		job.w = osvf_pkg::COEF_W'(wprod >> osvf_pkg::ANGLE_SHIFT);
		job.q = osvf_pkg::COEF_W'({damp, {osvf_pkg::DAMP_SHIFT{1'b0}}});

		case (cfg.filter_mode)
			osvf_pkg::MODE_LOWPASS: job.mode = osvf_pkg::MODE_LOWPASS;
			osvf_pkg::MODE_HIGHPASS: job.mode = osvf_pkg::MODE_HIGHPASS;
			osvf_pkg::MODE_BANDPASS: job.mode = osvf_pkg::MODE_BANDPASS;
			osvf_pkg::MODE_NOTCH: job.mode = osvf_pkg::MODE_NOTCH;
			default: job.mode = osvf_pkg::MODE_BYPASS;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/osvf_queue.sv
// Short job queue between the front end and the sequencer.
// Depends on osvf_pkg for the job type and depth; the depth is a power of two.
`default_nettype none

module osvf_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input osvf_pkg::job_t push_job,
	output logic full,
	input logic pop,
	output logic pop_valid,
	output osvf_pkg::job_t pop_job
);

	osvf_pkg::job_t entries_q [osvf_pkg::QDEPTH];
	logic [osvf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [osvf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [osvf_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == osvf_pkg::QCNT_W'(osvf_pkg::QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/osvf_back.sv
// Back end: a microcoded sequencer around one shared multiplier that computes the
// coefficient, runs three filter passes and the averages, then drives the output register;
// bypass jobs go straight to the output register. Depends on osvf_pkg and osvf_out_if.
`default_nettype none

module osvf_back (
	input logic clk,
	input logic arst_n,
	input logic deq_valid,
	input osvf_pkg::job_t deq_job,
	output logic pop,
	osvf_out_if.source out_ch
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t state_q;
	logic [osvf_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;
	logic signed [osvf_pkg::SAMPLE_WIDTH-1:0] out_sample_q;
	logic signed [osvf_pkg::SAMPLE_WIDTH-1:0] res_q;

	osvf_pkg::mode_t mode_q;
	logic signed [osvf_pkg::STATE_WIDTH-1:0] x_q;
	logic [osvf_pkg::COEF_W-1:0] w_q, q_q, w2_q, w3_q, w5_q, w7_q, f_q;
	logic signed [osvf_pkg::POLY_W-1:0] poly_q;
	logic signed [osvf_pkg::STATE_WIDTH-1:0] lp_q, bp_q, hp_q;
	logic signed [osvf_pkg::OPA_W-1:0] sl_q, sh_q, sb_q;
	logic signed [osvf_pkg::ACC_W-1:0] acc_q;
	logic signed [osvf_pkg::P_W-1:0] prod_q;

	osvf_pkg::micro_t uop;
	logic run;
	logic out_free;
	logic signed [osvf_pkg::OPA_W-1:0] opa;
	logic [osvf_pkg::COEF_W-1:0] opb;
	logic signed [osvf_pkg::P_W-1:0] prod_c;
	logic signed [osvf_pkg::R_W-1:0] r;
	logic signed [osvf_pkg::POLY_W-1:0] r_poly;
	logic signed [osvf_pkg::POLY_W-1:0] fdiff;
	logic signed [osvf_pkg::STATE_WIDTH-1:0] lp_new, hp_new, bp_new;
	logic signed [osvf_pkg::Y_W-1:0] y;
	logic signed [osvf_pkg::SAMPLE_WIDTH-1:0] res_c;

	assign uop = osvf_pkg::seq_op(step_q);
	assign run = (state_q == ST_RUN);
	assign pop = (state_q == ST_IDLE) && deq_valid;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.sample_out = out_sample_q;

	always_comb begin
		unique case (uop.opa)
			osvf_pkg::OPA_ANGLE: opa = osvf_pkg::OPA_W'(w_q);
			osvf_pkg::OPA_W2: opa = osvf_pkg::OPA_W'(w2_q);
			osvf_pkg::OPA_W3: opa = osvf_pkg::OPA_W'(w3_q);
			osvf_pkg::OPA_W5: opa = osvf_pkg::OPA_W'(w5_q);
			osvf_pkg::OPA_W7: opa = osvf_pkg::OPA_W'(w7_q);
			osvf_pkg::OPA_BP: opa = osvf_pkg::OPA_W'(bp_q);
			osvf_pkg::OPA_HP: opa = osvf_pkg::OPA_W'(hp_q);
			osvf_pkg::OPA_SH: opa = sh_q;
			osvf_pkg::OPA_AVG1: begin
				case (mode_q)
					osvf_pkg::MODE_HIGHPASS: opa = sh_q;
					osvf_pkg::MODE_BANDPASS: opa = sb_q;
					default: opa = sl_q;
				endcase
			end
			default: opa = '0;
		endcase

		unique case (uop.opb)
			osvf_pkg::OPB_W: opb = w_q;
			osvf_pkg::OPB_W2: opb = w2_q;
			osvf_pkg::OPB_T3: opb = osvf_pkg::TAYLOR3;
			osvf_pkg::OPB_T5: opb = osvf_pkg::TAYLOR5;
			osvf_pkg::OPB_T7: opb = osvf_pkg::TAYLOR7;
			osvf_pkg::OPB_F: opb = f_q;
			osvf_pkg::OPB_Q: opb = q_q;
			osvf_pkg::OPB_THIRD: opb = osvf_pkg::THIRD_Q22;
			default: opb = '0;
		endcase

		// Rounding half up is folded into the multiply so the retire step is a plain shift.
		prod_c = opa * $signed({1'b0, opb}) + osvf_pkg::ROUND_HALF;
		r = osvf_pkg::R_W'(prod_q >>> osvf_pkg::FRAC);
		r_poly = $signed(r[osvf_pkg::POLY_W-1:0]);
		fdiff = poly_q - r_poly;

		lp_new = osvf_pkg::sat_state(osvf_pkg::EXT_W'(lp_q) + osvf_pkg::EXT_W'(r));
		hp_new = osvf_pkg::sat_state(osvf_pkg::EXT_W'(x_q) - osvf_pkg::EXT_W'(lp_q)
			- osvf_pkg::EXT_W'(r));
		bp_new = osvf_pkg::sat_state(osvf_pkg::EXT_W'(bp_q) + osvf_pkg::EXT_W'(r));

		y = (osvf_pkg::Y_W'(acc_q) <<< osvf_pkg::XSH_L) >>> osvf_pkg::XSH_R;
		res_c = osvf_pkg::sat_sample(y);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= deq_job.mode;
			x_q <= deq_job.x;
			w_q <= deq_job.w;
			q_q <= deq_job.q;
			sl_q <= '0;
			sh_q <= '0;
			sb_q <= '0;
		end
		if (run && uop.issue) begin
			prod_q <= prod_c;
		end
		if (run) begin
			case (uop.dst)
				osvf_pkg::DST_W2: w2_q <= r[osvf_pkg::COEF_W-1:0];
				osvf_pkg::DST_W3: w3_q <= r[osvf_pkg::COEF_W-1:0];
				osvf_pkg::DST_W5: w5_q <= r[osvf_pkg::COEF_W-1:0];
				osvf_pkg::DST_W7: w7_q <= r[osvf_pkg::COEF_W-1:0];
				osvf_pkg::DST_T3: poly_q <= $signed({2'b00, w_q}) - r_poly;
				osvf_pkg::DST_T5: poly_q <= poly_q + r_poly;
				osvf_pkg::DST_T7: f_q <= {fdiff[osvf_pkg::COEF_W-2:0], 1'b0};
				osvf_pkg::DST_LP: sl_q <= sl_q + osvf_pkg::OPA_W'(lp_new);
				osvf_pkg::DST_HP: begin
					hp_q <= hp_new;
					sh_q <= sh_q + osvf_pkg::OPA_W'(hp_new);
				end
				osvf_pkg::DST_BP: sb_q <= sb_q + osvf_pkg::OPA_W'(bp_new);
				osvf_pkg::DST_ACC_SET: acc_q <= osvf_pkg::ACC_W'(r);
				osvf_pkg::DST_ACC_ADD: begin
					if (mode_q == osvf_pkg::MODE_NOTCH) begin
						acc_q <= acc_q + osvf_pkg::ACC_W'(r);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			bp_q <= '0;
		end else if (run) begin
			if (uop.dst == osvf_pkg::DST_LP) begin
				lp_q <= lp_new;
			end
			if (uop.dst == osvf_pkg::DST_BP) begin
				bp_q <= bp_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
			out_sample_q <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (deq_valid) begin
						if (deq_job.mode == osvf_pkg::MODE_BYPASS) begin
							res_q <= deq_job.raw;
							state_q <= ST_DONE;
						end else begin
							step_q <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (step_q == osvf_pkg::STEP_W'(osvf_pkg::SEQ_LAST)) begin
						res_q <= res_c;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_sample_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/oversampled_state_variable_filter.sv
// Oversampled state-variable filter, top level: configuration registers, front end,
// job queue and multiplier sequencer. Depends on osvf_pkg, osvf_if, osvf_front,
// osvf_queue and osvf_back.
// A filtered beat passes through the queue, the 29-step shared-multiplier sequence and the
// output register; a bypassed beat skips the sequence. The sequencer finishes one sample
// before it takes the next, and the two-entry queue absorbs input.
// Reset clears the filter state, the queue and the output, and loads the register defaults.
`default_nettype none

module oversampled_state_variable_filter (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [osvf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [osvf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	osvf_in_if.sink in_ch,
	osvf_out_if.source out_ch
);

	osvf_pkg::cfg_t cfg_q;
	logic push;
	logic full;
	logic pop;
	logic deq_valid;
	osvf_pkg::job_t enq_job;
	osvf_pkg::job_t deq_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode <= osvf_pkg::MODE_BYPASS;
			cfg_q.min_cutoff <= osvf_pkg::MIN_CUTOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				osvf_pkg::REG_FILTER_MODE: cfg_q.filter_mode <= cfg_wdata[osvf_pkg::MODE_W-1:0];
				osvf_pkg::REG_MIN_CUTOFF: cfg_q.min_cutoff <= cfg_wdata[osvf_pkg::CTRL_W-1:0];
				default: ;
			endcase
		end
	end

	osvf_front u_front (
		.in_ch(in_ch),
		.cfg(cfg_q),
		.full(full),
		.push(push),
		.job(enq_job)
	);

	osvf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(enq_job),
		.full(full),
		.pop(pop),
		.pop_valid(deq_valid),
		.pop_job(deq_job)
	);

	osvf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.deq_valid(deq_valid),
		.deq_job(deq_job),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire

>>> sim/oversampled_state_variable_filter_test.sv
// Self-checking bench for the oversampled state-variable filter: drives sample beats and
// register writes, predicts each output sample and compares it with what the block returns.
// Depends on osvf_pkg, osvf_if and the oversampled_state_variable_filter RTL.
`default_nettype none

module oversampled_state_variable_filter_test;
	import osvf_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PRINT_LIMIT = 40;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 95;

	// Mode codes that the block must treat as bypass.
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

	localparam longint HALF_LSB = 2097152;
	localparam longint ANGLE_SCALE = 2178742;
	localparam longint SIN_C3 = 699051;
	localparam longint SIN_C5 = 34953;
	localparam longint SIN_C7 = 832;
	localparam longint ONE_THIRD = 1398101;
	localparam longint CTRL_ONE = 65536;

	typedef logic signed [SW-1:0] sample_t;

	localparam sample_t SMP_TOP = {1'b0, {(SW-1){1'b1}}};
	localparam sample_t SMP_BOTTOM = {1'b1, {(SW-1){1'b0}}};
	localparam sample_t SMP_ZERO = '0;
	localparam sample_t SMP_NEG_ONE = '1;

	localparam logic [MODE_W-1:0] PHASE_MODE [NUM_PHASES] = '{
		MODE_LOWPASS, MODE_HIGHPASS, MODE_BANDPASS, MODE_NOTCH, MODE_BYPASS, MODE_LOWPASS,
		MODE_NOTCH, MODE_BANDPASS, MODE_HIGHPASS, MODE_SPARE_C, MODE_LOWPASS, MODE_NOTCH
	};
	localparam int PHASE_MIN_CUTOFF [NUM_PHASES] = '{
		0, 30, 65535, 1000, 0, 65535, 200, 12000, 30, 5, 65534, 3000
	};

	class svf_scoreboard;
		logic [MODE_W-1:0] mode_reg;
		logic [CTRL_W-1:0] min_cutoff_reg;
		longint lowpass_acc;
		longint bandpass_acc;
		sample_t expected_out[$];
		int errors;
		int checked;
		int filtered;
		int bypassed;

		function new();
			mode_reg = MODE_BYPASS;
			min_cutoff_reg = MIN_CUTOFF_RST;
			lowpass_acc = 0;
			bandpass_acc = 0;
			errors = 0;
			checked = 0;
			filtered = 0;
			bypassed = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_FILTER_MODE) begin
				mode_reg = value[MODE_W-1:0];
			end else if (idx == REG_MIN_CUTOFF) begin
				min_cutoff_reg = value[CTRL_W-1:0];
			end
		endfunction

		// Product of a Q22 coefficient and a value, rounded half up.
		function longint mul_q22(longint a, longint b);
			return (a * b + HALF_LSB) >>> FRAC;
		endfunction

		function longint clip_to(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				return hi;
			end else if (v < lo) begin
				return lo;
			end
			return v;
		endfunction

		function sample_t filter_sample(sample_t s, logic [CTRL_W-1:0] c,
				logic [CTRL_W-1:0] r);
			longint x, cc, w, w2, w3, w5, w7, f, q, lp, bp, hp, sum_lp, sum_hp, sum_bp;
			longint avg, y;
			if (mode_reg == MODE_BYPASS || mode_reg > MODE_NOTCH) begin
				bypassed++;
				return s;
			end
			filtered++;
			x = (longint'(s) >>> XSH_L) <<< XSH_R;
			cc = (c < min_cutoff_reg) ? longint'(min_cutoff_reg) : longint'(c);
			w = (cc * ANGLE_SCALE + 32768) >>> 16;
			w2 = mul_q22(w, w);
			w3 = mul_q22(w2, w);
			w5 = mul_q22(w3, w2);
			w7 = mul_q22(w5, w2);
			f = 2 * (w - mul_q22(w3, SIN_C3) + mul_q22(w5, SIN_C5) - mul_q22(w7, SIN_C7));
			q = (CTRL_ONE - longint'(r)) <<< 6;
			lp = lowpass_acc;
			bp = bandpass_acc;
			sum_lp = 0;
			sum_hp = 0;
			sum_bp = 0;
			for (int pass = 0; pass < 3; pass++) begin
				lp = clip_to(lp + mul_q22(bp, f), STATE_WIDTH);
				hp = clip_to(x - lp - mul_q22(bp, q), STATE_WIDTH);
				bp = clip_to(bp + mul_q22(hp, f), STATE_WIDTH);
				sum_lp += lp;
				sum_hp += hp;
				sum_bp += bp;
			end
			lowpass_acc = lp;
			bandpass_acc = bp;
			case (mode_reg)
				MODE_LOWPASS: avg = mul_q22(sum_lp, ONE_THIRD);
				MODE_HIGHPASS: avg = mul_q22(sum_hp, ONE_THIRD);
				MODE_BANDPASS: avg = mul_q22(sum_bp, ONE_THIRD);
				default: avg = mul_q22(sum_lp, ONE_THIRD) + mul_q22(sum_hp, ONE_THIRD);
			endcase
			y = (avg <<< XSH_L) >>> XSH_R;
			return sample_t'(clip_to(y, SW));
		endfunction

		function void note_sample(sample_t s, logic [CTRL_W-1:0] c, logic [CTRL_W-1:0] r);
			expected_out.push_back(filter_sample(s, c, r));
		endfunction

		function int pending();
			return expected_out.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_LIMIT) begin
				$display("error at %0t: %s", $realtime, what);
			end
		endtask

		task check_output(sample_t got);
			sample_t want;
			if (expected_out.size() == 0) begin
				report($sformatf("output beat %0d with no sample expected", got));
			end else begin
				want = expected_out.pop_front();
				checked++;
				if (got !== want) begin
					report($sformatf("sample_out %0d, expected %0d", got, want));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	bit quiet;
	int cycle_count;
	int settings_used;
	svf_scoreboard sb;

	osvf_in_if in_ch ();
	osvf_out_if out_ch ();

	oversampled_state_variable_filter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Mostly short gaps, a few long ones, none at all while quiet is set.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else begin
				out_ch.ready = 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				sb.check_output(out_ch.sample_out);
			end
		end
	end

	task send_sample(sample_t s, logic [CTRL_W-1:0] c, logic [CTRL_W-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.sample_in = s;
		in_ch.cutoff = c;
		in_ch.resonance = r;
		in_ch.valid = 1'b1;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		sb.note_sample(s, c, r);
		@(negedge clk);
	endtask

	task wait_idle();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_register(idx, value);
	endtask

	task set_regs(logic [MODE_W-1:0] mode, logic [CTRL_W-1:0] min_cutoff);
		wait_idle();
		cfg_write(REG_FILTER_MODE, CFG_DATA_W'(mode));
		cfg_write(REG_MIN_CUTOFF, min_cutoff);
		settings_used++;
	endtask

	initial begin
		int n, len, kind, half, waited;
		sample_t lvl, s;
		logic [CTRL_W-1:0] bc, br, c, r;
		sb = new();
		settings_used = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		in_ch.cutoff = '0;
		in_ch.resonance = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: field extremes in every mode, cutoff below the clamp,
		// a clamp at full scale, and the spare mode codes.
		set_regs(MODE_LOWPASS, MIN_CUTOFF_RST);
		send_sample(SMP_TOP, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_BOTTOM, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_ZERO, 16'h0000, 16'h0000);
		send_sample(SMP_NEG_ONE, 16'h0001, 16'h8000);
		set_regs(MODE_HIGHPASS, MIN_CUTOFF_RST);
		send_sample(SMP_TOP, 16'h0000, 16'hFFFF);
		send_sample(SMP_TOP, 16'hFFFF, 16'h0000);
		send_sample(SMP_BOTTOM, 16'h9C40, 16'h0001);
		send_sample(sample_t'(1), 16'h0064, 16'hFFFE);
		set_regs(MODE_BANDPASS, 16'h0000);
		send_sample(SMP_BOTTOM, 16'h0000, 16'hFFFF);
		send_sample(SMP_TOP, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_TOP, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_ZERO, 16'h5555, 16'hAAAA);
		set_regs(MODE_NOTCH, MIN_CUTOFF_RST);
		send_sample(SMP_TOP, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_BOTTOM, 16'hFFFF, 16'hFFFF);
		send_sample(SMP_BOTTOM, 16'h001D, 16'h0000);
		send_sample(SMP_NEG_ONE, 16'h001E, 16'hFFFF);
		set_regs(MODE_LOWPASS, 16'hFFFF);
		send_sample(SMP_TOP, 16'h0000, 16'h0000);
		send_sample(SMP_BOTTOM, 16'h0000, 16'hFFFF);
		set_regs(MODE_BYPASS, MIN_CUTOFF_RST);
		send_sample(SMP_TOP, 16'hFFFF, 16'h0000);
		send_sample(SMP_BOTTOM, 16'h0000, 16'hFFFF);
		set_regs(MODE_SPARE_A, MIN_CUTOFF_RST);
		send_sample(SMP_NEG_ONE, 16'h1234, 16'h4321);
		set_regs(MODE_SPARE_B, MIN_CUTOFF_RST);
		send_sample(SMP_TOP, 16'h0000, 16'h0000);
		set_regs(MODE_SPARE_C, MIN_CUTOFF_RST);
		send_sample(SMP_BOTTOM, 16'hFFFF, 16'hFFFF);

		// Random part: bursts of noise, tones, steps and extremes under each setting.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_regs(PHASE_MODE[ph], CTRL_W'(PHASE_MIN_CUTOFF[ph]));
			quiet = (ph % 4 == 1);
			n = 0;
			while (n < PHASE_ITEMS) begin
				kind = $urandom_range(0, 3);
				len = $urandom_range(5, 40);
				half = $urandom_range(1, 20);
				lvl = ($urandom_range(0, 2) == 0) ? SMP_TOP : sample_t'($urandom_range(0, 8388607));
				bc = ($urandom_range(0, 1) == 0) ? CTRL_W'($urandom()) : CTRL_W'($urandom_range(0, 4000));
				br = ($urandom_range(0, 1) == 0) ? CTRL_W'($urandom_range(60000, 65535))
					: CTRL_W'($urandom());
				for (int i = 0; i < len && n < PHASE_ITEMS; i++) begin
					c = bc;
					r = br;
					case (kind)
						0: begin
							s = sample_t'($urandom());
							c = CTRL_W'($urandom());
							r = CTRL_W'($urandom());
						end
						1: s = ((i / half) % 2 == 0) ? lvl : -lvl;
						2: s = lvl;
						default: begin
							case ($urandom_range(0, 3))
								0: s = SMP_TOP;
								1: s = SMP_BOTTOM;
								2: s = SMP_ZERO;
								default: s = SMP_NEG_ONE;
							endcase
							case ($urandom_range(0, 3))
								0: c = '0;
								1: c = '1;
								2: c = sb.min_cutoff_reg;
								default: c = CTRL_W'($urandom());
							endcase
							r = ($urandom_range(0, 1) == 0) ? '0 : '1;
						end
					endcase
					send_sample(s, c, r);
					n++;
					if ($urandom_range(0, 199) == 0) begin
						in_ch.valid = 1'b0;
						while (sb.pending() != 0) begin
							@(negedge clk);
						end
					end
				end
			end
		end
		in_ch.valid = 1'b0;
		quiet = 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (40) @(negedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d expected samples never came out", sb.pending()));
		end

		$display("Checked %0d output beats: %0d filtered and %0d bypassed samples",
			sb.checked, sb.filtered, sb.bypassed);
		$display("under %0d register settings, in %0d clock cycles.", settings_used, cycle_count);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
